// File: design/virtual_gpio_bridge_core_defines.svh
// Assertion macros shared by the virtual GPIO bridge modules.
`ifndef VIRTUAL_GPIO_BRIDGE_CORE_DEFINES_SVH
`define VIRTUAL_GPIO_BRIDGE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VGB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define VGB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define VGB_ASSERT(lbl, clk, rst_n, prop)
`define VGB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/vgb_pkg.sv
// Types, constants and helper functions of the virtual GPIO bridge.
package vgb_pkg;

	localparam int PIN_COUNT     = 8;
	localparam int PIN_SLOTS     = 8;
	localparam int PIN_W         = 3;
	localparam int CMD_W         = 3;
	localparam int VAL_W         = 10;
	localparam int CHAR_W        = 8;
	localparam int MODES_W       = 16;
	localparam int CNT_W         = 17;
	localparam int APB_ADDR_W    = 4;
	localparam int APB_DATA_W    = 32;

	localparam int ANALOG_RANGE  = 255;
	localparam int RANGE_W       = 10;
	localparam int ANA_SCALE     = 127;
	localparam int ANA_OFFSET    = 2;
	localparam int ANA_LEVEL_MAX = 129;
	localparam int REPORT_BASE   = 128;
	localparam int PROD_W        = VAL_W + $clog2(ANA_SCALE + 1);
	localparam int DIV_SHIFT     = PROD_W;
	localparam int RECIP_W       = DIV_SHIFT + 1;
	localparam int ANA_RECIP     = (1 << DIV_SHIFT) / ANALOG_RANGE;

	localparam logic [CNT_W-1:0] RESET_READY_DELAY  = CNT_W'(2000);
	localparam logic [CNT_W-1:0] RESET_CONN_TIMEOUT = CNT_W'(60000);
	localparam logic [CNT_W-1:0] RESET_IDLE_TIMEOUT = CNT_W'(5000);

	localparam logic [1:0] REG_PIN_MODES    = 2'd0;
	localparam logic [1:0] REG_READY_DELAY  = 2'd1;
	localparam logic [1:0] REG_CONN_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd3;

	localparam logic [1:0] MODE_INPUT  = 2'd0;
	localparam logic [1:0] MODE_PULLUP = 2'd1;
	localparam logic [1:0] MODE_OUTPUT = 2'd2;
	localparam logic [1:0] MODE_UNSET  = 2'd3;

	localparam logic [PIN_W-1:0] REP_LAST = PIN_W'(PIN_SLOTS - 1);

	localparam logic [CHAR_W-1:0] CHAR_PRESENCE = 8'h38;
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ONE      = 8'h31;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 3'd0,
		CMD_PRESENCE  = 3'd1,
		CMD_REPORT    = 3'd2,
		CMD_SET_INPUT = 3'd3,
		CMD_DIG_WRITE = 3'd4,
		CMD_ANA_WRITE = 3'd5,
		CMD_READ      = 3'd6,
		CMD_RESERVED  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		RM_NONE  = 3'd0,
		RM_IN_LO = 3'd1,
		RM_IN_HI = 3'd2,
		RM_PU_LO = 3'd3,
		RM_PU_HI = 3'd4,
		RM_OUT   = 3'd5,
		RM_UNSET = 3'd6
	} rmode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ANA_MUL,
		ST_ANA_DIV,
		ST_REPORT
	} ctrl_state_t;

	typedef struct packed {
		logic [MODES_W-1:0] pin_modes;
		logic [CNT_W-1:0]   ready_delay;
		logic [CNT_W-1:0]   connect_timeout;
		logic [CNT_W-1:0]   idle_timeout;
	} vgb_cfg_t;

	typedef struct packed {
		logic             take;
		logic             exec;
		logic             ana_mul;
		logic             ana_div;
		logic             emit_report;
		logic [PIN_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid;
		cmd_t in_cmd;
		logic slot_free;
	} dp_stat_t;

	function automatic logic [1:0] pin_mode(logic [MODES_W-1:0] modes, logic [PIN_W-1:0] p);
		if (int'(p) >= PIN_COUNT) return MODE_UNSET;
		return modes[2*p +: 2];
	endfunction

	function automatic logic [CHAR_W-1:0] rm_char(rmode_t code);
		logic [CHAR_W-1:0] c;
		case (code)
			RM_IN_LO: c = 8'h69;
			RM_IN_HI: c = 8'h49;
			RM_PU_LO: c = 8'h75;
			RM_PU_HI: c = 8'h55;
			RM_OUT:   c = 8'h4F;
			RM_UNSET: c = 8'h58;
			default:  c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: design/vgb_in_if.sv
// Input channel of the bridge: command beats from the host.
interface vgb_in_if;
	import vgb_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [PIN_W-1:0] pin;
	logic [VAL_W-1:0] value;

	modport source (output valid, command, pin, value, input ready);
	modport sink   (input valid, command, pin, value, output ready);
endinterface

// File: design/vgb_out_if.sv
// Output channel of the bridge: result beats to the host.
interface vgb_out_if;
	import vgb_pkg::*;

	logic              valid;
	logic              ready;
	logic              status;
	logic [CHAR_W-1:0] reply_char;
	logic [7:0]        read_value;
	logic              link_ready;
	logic              link_failed;
	logic              last;

	modport source (output valid, status, reply_char, read_value, link_ready, link_failed, last,
		input ready);
	modport sink   (input valid, status, reply_char, read_value, link_ready, link_failed, last,
		output ready);
endinterface

// File: design/vgb_regs.sv
// APB configuration registers of the bridge.
module vgb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vgb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vgb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [vgb_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output vgb_pkg::vgb_cfg_t              cfg
);
	import vgb_pkg::*;

	vgb_cfg_t   cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pin_modes       <= '0;
			cfg_q.ready_delay     <= RESET_READY_DELAY;
			cfg_q.connect_timeout <= RESET_CONN_TIMEOUT;
			cfg_q.idle_timeout    <= RESET_IDLE_TIMEOUT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PIN_MODES:    cfg_q.pin_modes       <= pwdata[MODES_W-1:0];
				REG_READY_DELAY:  cfg_q.ready_delay     <= pwdata[CNT_W-1:0];
				REG_CONN_TIMEOUT: cfg_q.connect_timeout <= pwdata[CNT_W-1:0];
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout    <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PIN_MODES:    prdata = APB_DATA_W'(cfg_q.pin_modes);
			REG_READY_DELAY:  prdata = APB_DATA_W'(cfg_q.ready_delay);
			REG_CONN_TIMEOUT: prdata = APB_DATA_W'(cfg_q.connect_timeout);
			REG_IDLE_TIMEOUT: prdata = APB_DATA_W'(cfg_q.idle_timeout);
			default:          prdata = '0;
		endcase
	end
endmodule

// File: design/vgb_ctrl.sv
// Sequencer of the bridge: accepts beats and steps the datapath through each command.
`include "virtual_gpio_bridge_core_defines.svh"
module vgb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  vgb_pkg::dp_stat_t stat,
	output vgb_pkg::dp_cmd_t  cmd
);
	import vgb_pkg::*;

	ctrl_state_t      state_q, state_d;
	logic [PIN_W-1:0] k_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) begin
					unique case (stat.in_cmd)
						CMD_ANA_WRITE: state_d = ST_ANA_MUL;
						CMD_REPORT:    state_d = ST_REPORT;
						default:       state_d = ST_EXEC;
					endcase
				end
			end
			ST_ANA_MUL: state_d = ST_ANA_DIV;
			ST_ANA_DIV: state_d = ST_EXEC;
			ST_EXEC: begin
				if (stat.slot_free) state_d = ST_IDLE;
			end
			ST_REPORT: begin
				if (stat.slot_free && k_q == REP_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.idx = k_q;
		unique case (state_q)
			ST_IDLE:    cmd.take        = 1'b1;
			ST_ANA_MUL: cmd.ana_mul     = 1'b1;
			ST_ANA_DIV: cmd.ana_div     = 1'b1;
			ST_EXEC:    cmd.exec        = stat.slot_free;
			ST_REPORT:  cmd.emit_report = stat.slot_free;
			default:    cmd.take        = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			// advance one pin per report beat; wraps back to pin zero after the last
			if (cmd.emit_report) k_q <= k_q + PIN_W'(1);
		end
	end

	`VGB_ASSERT(a_report_start, clk, arst_n, state_q == ST_IDLE && stat.in_valid && stat.in_cmd == CMD_REPORT |=> state_q == ST_REPORT && k_q == '0)
	`VGB_ASSERT(a_report_end, clk, arst_n, state_q == ST_REPORT && stat.slot_free && k_q == REP_LAST |=> state_q == ST_IDLE)
	`VGB_ASSERT(a_analog_seq, clk, arst_n, state_q == ST_ANA_MUL |=> state_q == ST_ANA_DIV ##1 state_q == ST_EXEC)
endmodule

// File: design/vgb_datapath.sv
// Datapath of the bridge: pin state, watchdog, analog scaling and the result register.
`include "virtual_gpio_bridge_core_defines.svh"
module vgb_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  vgb_pkg::vgb_cfg_t cfg,
	input  vgb_pkg::dp_cmd_t  cmd,
	output vgb_pkg::dp_stat_t stat,
	vgb_in_if.sink            in_ch,
	vgb_out_if.source         out_ch
);
	import vgb_pkg::*;

	localparam int MULW = PROD_W + RECIP_W;
	localparam int BACKW = PROD_W + RANGE_W;

	// latched command beat
	cmd_t             cmd_q;
	logic [PIN_W-1:0] pin_q;
	logic [VAL_W-1:0] val_q;

	// analog scaling pipeline
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] qe_q;
	logic [MULW-1:0]   recip_prod;
	logic [BACKW-1:0]  back_prod;
	logic [PROD_W-1:0] rem;
	logic [PROD_W-1:0] q_fix;
	logic [PROD_W:0]   level;

	// pin and link state
	logic [PIN_SLOTS-1:0] input_bits_q, input_bits_d;
	logic [7:0]           output_values_q [PIN_SLOTS];
	logic [7:0]           output_values_d [PIN_SLOTS];
	rmode_t               reported_q [PIN_SLOTS];
	rmode_t               reported_d [PIN_SLOTS];
	logic                 active_q, active_d;
	logic                 stage_one_q, stage_one_d;
	logic                 stage_two_q, stage_two_d;
	logic                 failed_q, failed_d;
	logic [CNT_W-1:0]     start_q, start_d;
	logic [CNT_W-1:0]     act_q, act_d;

	// watchdog step
	logic             wd_active, wd_s1, wd_s2, wd_fail;
	logic [CNT_W-1:0] wd_start, wd_act;

	// pin lookup
	logic [PIN_W-1:0] rd_idx;
	logic             pin_ok;
	logic [1:0]       mode_cur;
	logic             in_bit;
	logic [7:0]       out_val;
	rmode_t           code;

	// result register
	logic              out_load;
	logic              slot_free;
	logic              o_status;
	logic [CHAR_W-1:0] o_char;
	logic [7:0]        o_rval;
	logic              o_last;
	logic              out_valid_q;
	logic              status_q;
	logic [CHAR_W-1:0] char_q;
	logic [7:0]        rval_q;
	logic              ready_q;
	logic              failed_out_q;
	logic              last_q;

	assign slot_free      = !out_valid_q || out_ch.ready;
	assign in_ch.ready    = cmd.take;
	assign stat.in_valid  = in_ch.valid;
	assign stat.in_cmd    = cmd_t'(in_ch.command);
	assign stat.slot_free = slot_free;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.reply_char  = char_q;
	assign out_ch.read_value  = rval_q;
	assign out_ch.link_ready  = ready_q;
	assign out_ch.link_failed = failed_out_q;
	assign out_ch.last        = last_q;

	// quotient estimate is low by at most one; one compare fixes it
	assign recip_prod = MULW'(prod_q) * MULW'(ANA_RECIP);
	assign back_prod  = BACKW'(qe_q) * BACKW'(ANALOG_RANGE);
	assign rem        = prod_q - back_prod[PROD_W-1:0];
	assign q_fix      = qe_q + PROD_W'(rem >= PROD_W'(ANALOG_RANGE));
	assign level      = (PROD_W+1)'(q_fix) + (PROD_W+1)'(ANA_OFFSET);

	assign rd_idx   = cmd.emit_report ? cmd.idx : pin_q;
	assign pin_ok   = int'(rd_idx) < PIN_COUNT;
	assign mode_cur = pin_mode(cfg.pin_modes, rd_idx);
	assign in_bit   = input_bits_q[rd_idx];
	assign out_val  = output_values_q[rd_idx];

	always_comb begin
		case (mode_cur)
			MODE_INPUT:  code = in_bit ? RM_IN_HI : RM_IN_LO;
			MODE_PULLUP: code = in_bit ? RM_PU_HI : RM_PU_LO;
			MODE_OUTPUT: code = RM_OUT;
			default:     code = RM_UNSET;
		endcase
	end

	always_comb begin
		wd_start  = (&start_q) ? start_q : start_q + CNT_W'(1);
		wd_act    = (&act_q) ? act_q : act_q + CNT_W'(1);
		wd_active = active_q;
		wd_s1     = stage_one_q;
		wd_s2     = stage_two_q;
		wd_fail   = failed_q;
		// a failed link holds until reset
		if (!failed_q) begin
			if (active_q && !wd_s1) begin
				wd_start = '0;
				wd_s1    = 1'b1;
			end
			if (wd_s1 && !wd_s2 && wd_start > cfg.ready_delay) wd_s2 = 1'b1;
			if (!wd_s1 && !wd_s2 && wd_start > cfg.connect_timeout) wd_fail = 1'b1;
			if (wd_s2 && wd_act > cfg.idle_timeout) begin
				wd_start  = '0;
				wd_act    = '0;
				wd_active = 1'b0;
				wd_s1     = 1'b0;
				wd_s2     = 1'b0;
			end
		end
	end

	always_comb begin
		input_bits_d    = input_bits_q;
		output_values_d = output_values_q;
		reported_d      = reported_q;
		active_d        = active_q;
		stage_one_d     = stage_one_q;
		stage_two_d     = stage_two_q;
		failed_d        = failed_q;
		start_d         = start_q;
		act_d           = act_q;
		out_load        = 1'b0;
		o_status        = 1'b0;
		o_char          = '0;
		o_rval          = '0;
		o_last          = 1'b1;

		if (cmd.exec) begin
			out_load = 1'b1;
			case (cmd_q)
				CMD_TICK: begin
					active_d    = wd_active;
					stage_one_d = wd_s1;
					stage_two_d = wd_s2;
					failed_d    = wd_fail;
					start_d     = wd_start;
					act_d       = wd_act;
				end
				CMD_PRESENCE: begin
					o_char   = CHAR_PRESENCE;
					active_d = 1'b1;
					act_d    = '0;
				end
				CMD_SET_INPUT: begin
					if (pin_ok) begin
						if (val_q <= VAL_W'(1)) input_bits_d[rd_idx] = val_q[0];
						else o_status = 1'b1;
						active_d = 1'b1;
						act_d    = '0;
					end
				end
				CMD_DIG_WRITE: begin
					if (pin_ok) output_values_d[rd_idx] = (val_q > VAL_W'(255)) ? 8'hFF : val_q[7:0];
				end
				CMD_ANA_WRITE: begin
					if (pin_ok && level <= (PROD_W+1)'(ANA_LEVEL_MAX))
						output_values_d[rd_idx] = level[7:0];
				end
				CMD_READ: begin
					if (stage_two_q && pin_ok) begin
						if (mode_cur == MODE_INPUT || mode_cur == MODE_PULLUP)
							o_rval = {7'b0, in_bit};
						else
							o_rval = out_val;
					end
				end
				default: ;
			endcase
		end else if (cmd.emit_report) begin
			out_load = 1'b1;
			o_last   = (cmd.idx == REP_LAST);
			active_d = 1'b1;
			act_d    = '0;
			if (reported_q[rd_idx] != code) begin
				o_char = rm_char(code);
				if (pin_ok) reported_d[rd_idx] = code;
			end else if (code == RM_OUT) begin
				if (out_val == 8'd0) o_char = CHAR_ZERO;
				else if (out_val == 8'd1) o_char = CHAR_ONE;
				else o_char = out_val - 8'(ANA_OFFSET) + 8'(REPORT_BASE);
			end else begin
				o_char = rm_char(code);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && in_ch.valid) begin
			cmd_q <= cmd_t'(in_ch.command);
			pin_q <= in_ch.pin;
			val_q <= in_ch.value;
		end
		if (cmd.ana_mul) prod_q <= PROD_W'(val_q) * PROD_W'(ANA_SCALE);
		if (cmd.ana_div) qe_q <= PROD_W'(recip_prod >> DIV_SHIFT);
		if (out_load) begin
			status_q     <= o_status;
			char_q       <= o_char;
			rval_q       <= o_rval;
			ready_q      <= stage_two_d;
			failed_out_q <= failed_d;
			last_q       <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_bits_q <= '0;
			for (int i = 0; i < PIN_SLOTS; i++) begin
				output_values_q[i] <= '0;
				reported_q[i]      <= RM_NONE;
			end
			active_q    <= 1'b0;
			stage_one_q <= 1'b0;
			stage_two_q <= 1'b0;
			failed_q    <= 1'b0;
			start_q     <= '0;
			act_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			input_bits_q    <= input_bits_d;
			output_values_q <= output_values_d;
			reported_q      <= reported_d;
			active_q        <= active_d;
			stage_one_q     <= stage_one_d;
			stage_two_q     <= stage_two_d;
			failed_q        <= failed_d;
			start_q         <= start_d;
			act_q           <= act_d;
			// hold the beat until taken
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	`VGB_ASSERT(a_ready_needs_start, clk, arst_n, stage_two_q |-> stage_one_q)
	`VGB_ASSERT(a_failed_is_down, clk, arst_n, failed_q |-> !stage_one_q && !stage_two_q)
	`VGB_ASSERT_NEVER(a_load_when_full, clk, arst_n, out_load && !slot_free)
endmodule

// File: design/virtual_gpio_bridge_core.sv
// Virtual GPIO bridge core: eight virtual pins, link watchdog and report walker.
// A beat is taken in the idle state; a single-result command then passes through the execute state,
// an analog write first through two registered multiply steps of the scaler (multiply, then divide),
// and a state report gives one beat per pin; a held result register stalls each of them.
// Reset is asynchronous and active low; it clears all pin and link state at once and
// loads the configuration registers with their defaults.
module virtual_gpio_bridge_core (
	input  logic                           clk,
	input  logic                           arst_n,
	vgb_in_if.sink                         in_ch,
	vgb_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vgb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vgb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [vgb_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import vgb_pkg::*;

	vgb_cfg_t cfg;
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	vgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vgb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (dp_stat),
		.cmd    (dp_cmd)
	);

	vgb_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);
endmodule

// File: tb/virtual_gpio_bridge_core_tb.sv
// Self-checking testbench of the virtual GPIO bridge core: directed script, random items, APB setup.
module virtual_gpio_bridge_core_tb;
	import vgb_pkg::*;

	localparam int LIMIT = 400000;
	localparam logic [CNT_W-1:0] CNT_TOP = '1;

	typedef struct packed {
		logic       status;
		logic [7:0] reply_char;
		logic [7:0] read_value;
		logic       link_ready;
		logic       link_failed;
		logic       last;
	} reply_t;

	typedef struct {
		bit                  is_cfg;
		logic [1:0]          regi;
		logic [31:0]         data;
		cmd_t                cmd;
		logic [PIN_W-1:0]    pin;
		logic [VAL_W-1:0]    value;
		bit                  typed;
		reply_t              want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	vgb_in_if  in_ch ();
	vgb_out_if out_ch ();

	virtual_gpio_bridge_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the bridge state and its register settings.
	logic [MODES_W-1:0] cfg_modes = '0;
	logic [CNT_W-1:0]   cfg_ready = RESET_READY_DELAY;
	logic [CNT_W-1:0]   cfg_conn  = RESET_CONN_TIMEOUT;
	logic [CNT_W-1:0]   cfg_idle  = RESET_IDLE_TIMEOUT;
	logic               pin_in [PIN_SLOTS] = '{default: 1'b0};
	logic [7:0]         pin_out [PIN_SLOTS] = '{default: 8'd0};
	rmode_t             shown_mode [PIN_SLOTS] = '{default: RM_NONE};
	logic               link_active = 1'b0;
	logic               link_up1 = 1'b0;
	logic               link_up2 = 1'b0;
	logic               link_dead = 1'b0;
	logic [CNT_W-1:0]   start_ms = '0;
	logic [CNT_W-1:0]   quiet_ms = '0;

	reply_t reply_q [$];
	int     mismatches = 0;
	int     cycles = 0;
	bit     tx_gaps = 1'b1;
	bit     rx_gaps = 1'b1;
	bit     rx_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void touch_link();
		link_active = 1'b1;
		quiet_ms = '0;
	endfunction

	function automatic void tick_link();
		if (start_ms < CNT_TOP) start_ms++;
		if (quiet_ms < CNT_TOP) quiet_ms++;
		if (link_dead) return;
		if (link_active && !link_up1) begin
			start_ms = '0;
			link_up1 = 1'b1;
		end
		if (link_up1 && !link_up2 && start_ms > cfg_ready) link_up2 = 1'b1;
		if (!link_up1 && !link_up2 && start_ms > cfg_conn) link_dead = 1'b1;
		if (link_up2 && quiet_ms > cfg_idle) begin
			start_ms = '0;
			quiet_ms = '0;
			link_active = 1'b0;
			link_up1 = 1'b0;
			link_up2 = 1'b0;
		end
	endfunction

	function automatic logic [7:0] mode_letter(rmode_t code);
		case (code)
			RM_IN_LO: return "i";
			RM_IN_HI: return "I";
			RM_PU_LO: return "u";
			RM_PU_HI: return "U";
			RM_OUT:   return "O";
			RM_UNSET: return "X";
			default:  return 8'd0;
		endcase
	endfunction

	// Give the mode letter once after a mode change, else an output pin's value or the mode letter again.
	function automatic logic [7:0] report_char(int k);
		rmode_t code;
		if (k >= PIN_COUNT) code = RM_UNSET;
		else case (cfg_modes[2*k +: 2])
			MODE_INPUT:  code = pin_in[k] ? RM_IN_HI : RM_IN_LO;
			MODE_PULLUP: code = pin_in[k] ? RM_PU_HI : RM_PU_LO;
			MODE_OUTPUT: code = RM_OUT;
			default:     code = RM_UNSET;
		endcase
		if (shown_mode[k] != code) begin
			if (k < PIN_COUNT) shown_mode[k] = code;
			return mode_letter(code);
		end
		if (code == RM_OUT) begin
			if (pin_out[k] == 8'd0) return CHAR_ZERO;
			if (pin_out[k] == 8'd1) return CHAR_ONE;
			return 8'(pin_out[k] + 8'd126);
		end
		return mode_letter(code);
	endfunction

	// Apply one command to the mirror and queue the replies it must produce.
	function automatic void bridge_apply(cmd_t c, logic [PIN_W-1:0] p, logic [VAL_W-1:0] v);
		reply_t r;
		int     k;
		int     lvl;
		bit     pin_ok;
		logic [1:0] m;
		r = '0;
		r.last = 1'b1;
		pin_ok = int'(p) < PIN_COUNT;
		if (c == CMD_REPORT) begin
			touch_link();
			for (k = 0; k < PIN_SLOTS; k++) begin
				r.reply_char = report_char(k);
				r.link_ready = link_up2;
				r.link_failed = link_dead;
				r.last = (k == PIN_SLOTS - 1);
				reply_q.push_back(r);
			end
			return;
		end
		case (c)
			CMD_TICK: tick_link();
			CMD_PRESENCE: begin
				r.reply_char = CHAR_PRESENCE;
				touch_link();
			end
			CMD_SET_INPUT: if (pin_ok) begin
				if (v <= 1) pin_in[p] = v[0];
				else r.status = 1'b1;
				touch_link();
			end
			CMD_DIG_WRITE: if (pin_ok) pin_out[p] = (v > 255) ? 8'd255 : v[7:0];
			CMD_ANA_WRITE: begin
				lvl = (int'(v) * 127) / ANALOG_RANGE + 2;
				if (pin_ok && lvl <= 129) pin_out[p] = 8'(lvl);
			end
			CMD_READ: if (link_up2 && pin_ok) begin
				m = cfg_modes[2*p +: 2];
				r.read_value = (m == MODE_INPUT || m == MODE_PULLUP) ? {7'd0, pin_in[p]} :
					pin_out[p];
			end
			default: ;
		endcase
		r.link_ready = link_up2;
		r.link_failed = link_dead;
		reply_q.push_back(r);
	endfunction

	function automatic script_row_t item_row(cmd_t c, logic [PIN_W-1:0] p, logic [VAL_W-1:0] v);
		script_row_t r;
		r.is_cfg = 1'b0;
		r.regi = REG_PIN_MODES;
		r.data = '0;
		r.cmd = c;
		r.pin = p;
		r.value = v;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// Row whose single reply is plain from the command alone; link still down.
	function automatic script_row_t check_row(cmd_t c, logic [PIN_W-1:0] p, logic [VAL_W-1:0] v,
			logic st, logic [7:0] ch, logic [7:0] rv);
		script_row_t r;
		r = item_row(c, p, v);
		r.typed = 1'b1;
		r.want = '{status: st, reply_char: ch, read_value: rv, link_ready: 1'b0,
			link_failed: 1'b0, last: 1'b1};
		return r;
	endfunction

	function automatic script_row_t cfg_row(logic [1:0] idx, logic [31:0] d);
		script_row_t r;
		r = item_row(CMD_TICK, '0, '0);
		r.is_cfg = 1'b1;
		r.regi = idx;
		r.data = d;
		return r;
	endfunction

	// Entered right after a rising edge; returns at the edge where the beat is taken.
	task automatic send_item(cmd_t c, logic [PIN_W-1:0] p, logic [VAL_W-1:0] v, bit typed,
			reply_t want);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= c;
		in_ch.pin <= p;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
		bridge_apply(c, p, v);
		if (typed) reply_q[$] = want;
	endtask

	// Drain the bridge, then write one register over APB.
	task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
		in_ch.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PIN_MODES:    cfg_modes = d[MODES_W-1:0];
			REG_READY_DELAY:  cfg_ready = d[CNT_W-1:0];
			REG_CONN_TIMEOUT: cfg_conn = d[CNT_W-1:0];
			REG_IDLE_TIMEOUT: cfg_idle = d[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic random_items(int n);
		int               pick;
		cmd_t             c;
		logic [PIN_W-1:0] p;
		logic [VAL_W-1:0] v;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			p = PIN_W'($urandom_range(0, 7));
			v = VAL_W'($urandom_range(0, 1023));
			if (pick < 40) c = CMD_TICK;
			else if (pick < 48) c = CMD_PRESENCE;
			else if (pick < 56) c = CMD_REPORT;
			else if (pick < 68) begin
				c = CMD_SET_INPUT;
				if ($urandom_range(0, 5) != 0) v = VAL_W'($urandom_range(0, 1));
			end else if (pick < 78) begin
				c = CMD_DIG_WRITE;
				if ($urandom_range(0, 1) != 0) v = VAL_W'($urandom_range(0, 3));
			end else if (pick < 88) begin
				c = CMD_ANA_WRITE;
				if ($urandom_range(0, 1) != 0) v = VAL_W'($urandom_range(250, 265));
			end else if (pick < 98) c = CMD_READ;
			else c = CMD_RESERVED;
			send_item(c, p, v, 1'b0, '0);
		end
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result side: stall at random, take beats, check each against the oldest expectation.
	initial begin
		int     stall;
		reply_t want;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				stall = 250;
				rx_hold_req = 1'b0;
			end else begin
				stall = rx_gaps ? $urandom_range(0, 17) : 0;
			end
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (reply_q.size() == 0) begin
				$display("%0t: result beat with none expected: expected nothing, got char %0h",
					$time, out_ch.reply_char);
				mismatches++;
			end else begin
				want = reply_q.pop_front();
				compare_field("status", 8'(want.status), 8'(out_ch.status));
				compare_field("reply_char", want.reply_char, out_ch.reply_char);
				compare_field("read_value", want.read_value, out_ch.read_value);
				compare_field("link_ready", 8'(want.link_ready), 8'(out_ch.link_ready));
				compare_field("link_failed", 8'(want.link_failed), 8'(out_ch.link_failed));
				compare_field("last", 8'(want.last), 8'(out_ch.last));
			end
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: cycle limit reached, %0d results outstanding", $time, reply_q.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		script_row_t script [$];
		int          k;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_TICK;
		in_ch.pin <= '0;
		in_ch.value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		script.push_back(check_row(CMD_TICK, 0, 0, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_RESERVED, 7, 1023, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_READ, 3, 0, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_PRESENCE, 0, 0, 1'b0, CHAR_PRESENCE, 8'd0));
		script.push_back(check_row(CMD_SET_INPUT, 0, 1, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_SET_INPUT, 7, 1023, 1'b1, 8'd0, 8'd0));
		script.push_back(check_row(CMD_SET_INPUT, 5, 2, 1'b1, 8'd0, 8'd0));
		script.push_back(check_row(CMD_SET_INPUT, 7, 1, 1'b0, 8'd0, 8'd0));
		script.push_back(item_row(CMD_REPORT, 0, 0));
		script.push_back(check_row(CMD_DIG_WRITE, 0, 0, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_DIG_WRITE, 2, 2, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_DIG_WRITE, 3, 256, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_DIG_WRITE, 6, 1023, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_ANA_WRITE, 6, 258, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_ANA_WRITE, 4, 257, 1'b0, 8'd0, 8'd0));
		script.push_back(check_row(CMD_ANA_WRITE, 1, 0, 1'b0, 8'd0, 8'd0));
		// pins 0/4 input, 1/5 pullup, 2/6 output, 3/7 unset
		script.push_back(cfg_row(REG_PIN_MODES, 32'h0000_E4E4));
		script.push_back(cfg_row(REG_READY_DELAY, 32'd0));
		script.push_back(cfg_row(REG_IDLE_TIMEOUT, 32'd2));
		script.push_back(item_row(CMD_REPORT, 0, 0));
		script.push_back(item_row(CMD_REPORT, 0, 0));
		script.push_back(item_row(CMD_TICK, 0, 0));
		script.push_back(item_row(CMD_TICK, 0, 0));
		script.push_back(item_row(CMD_READ, 6, 0));
		script.push_back(item_row(CMD_READ, 1, 0));
		// third quiet tick exceeds the idle timeout and drops the link
		script.push_back(item_row(CMD_TICK, 0, 0));
		script.push_back(item_row(CMD_DIG_WRITE, 2, 1));
		script.push_back(item_row(CMD_REPORT, 0, 0));
		foreach (script[n]) begin
			if (script[n].is_cfg) cfg_write(script[n].regi, script[n].data);
			else send_item(script[n].cmd, script[n].pin, script[n].value, script[n].typed,
				script[n].want);
		end

		cfg_write(REG_PIN_MODES, $urandom_range(0, 65535));
		cfg_write(REG_READY_DELAY, $urandom_range(0, 4));
		cfg_write(REG_CONN_TIMEOUT, 32'd131071);
		cfg_write(REG_IDLE_TIMEOUT, $urandom_range(1, 6));
		random_items(20);

		// back-to-back beats while the result side holds off: fill the bridge
		cfg_write(REG_PIN_MODES, 32'h0000_FFFF);
		cfg_write(REG_READY_DELAY, 32'd131071);
		cfg_write(REG_IDLE_TIMEOUT, 32'd131071);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		rx_hold_req = 1'b1;
		random_items(15);

		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		cfg_write(REG_PIN_MODES, $urandom_range(0, 65535));
		cfg_write(REG_READY_DELAY, 32'd1);
		cfg_write(REG_IDLE_TIMEOUT, 32'd0);
		random_items(15);

		cfg_write(REG_PIN_MODES, $urandom_range(0, 65535));
		cfg_write(REG_READY_DELAY, 32'd0);
		cfg_write(REG_CONN_TIMEOUT, 32'd0);
		random_items(10);
		// bring the link up, let it drop, then run into the start timeout
		send_item(CMD_PRESENCE, 0, 0, 1'b0, '0);
		for (k = 0; k < 10; k++) send_item(CMD_TICK, 0, 0, 1'b0, '0);
		random_items(5);

		in_ch.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/vgb_pkg.sv
design/vgb_in_if.sv
design/vgb_out_if.sv
design/vgb_regs.sv
design/vgb_ctrl.sv
design/vgb_datapath.sv
design/virtual_gpio_bridge_core.sv
tb/virtual_gpio_bridge_core_tb.sv
